FILE: sv/sprite_plane_reorder_decrypt_core_macros.svh
// Assertion macros for the sprite plane reorder/decrypt core
`ifndef SPRITE_PLANE_REORDER_DECRYPT_CORE_MACROS_SVH
`define SPRITE_PLANE_REORDER_DECRYPT_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SPR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/spr_pkg.sv
// Shared types, constants and decode functions for the sprite plane core
`timescale 1ns / 1ps

package spr_pkg;

    localparam int BYTE_W      = 8;
    localparam int GROUP_WORDS = 32;
    localparam int HALF_WORDS  = GROUP_WORDS / 2;
    localparam int POS_W       = $clog2(GROUP_WORDS);
    localparam int ADDR_W      = $clog2(HALF_WORDS);

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        byte_t p0_even;
        byte_t p0_odd;
        byte_t p1_even;
        byte_t p1_odd;
        byte_t p2_even;
        byte_t p2_odd;
    } item_t;

    typedef struct packed {
        byte_t q0_even;
        byte_t q0_odd;
        byte_t q1_even;
        byte_t q1_odd;
        byte_t q2_even;
        byte_t q2_odd;
    } plane_out_t;

    // plane 0: addend, carry mask, key
    localparam logic [15:0] P0_ADD   = 16'h018a;
    localparam logic [15:0] P0_CMASK = 16'h018a;
    localparam logic [15:0] P0_KEY   = 16'hccd8;

    // bytes of the permuted word, lowest first
    localparam byte_t B0_ADD = 8'h05, B0_CMASK = 8'h1d, B0_KEY = 8'h6c;
    localparam byte_t B1_ADD = 8'h42, B1_CMASK = 8'h46, B1_KEY = 8'ha2;
    localparam byte_t B2_ADD = 8'h21, B2_CMASK = 8'h27, B2_KEY = 8'h52;
    localparam byte_t B3_ADD = 8'h08, B3_CMASK = 8'h08, B3_KEY = 8'h3a;

    // source bit for result bit 31-i
    localparam logic [4:0] PERM_SRC [32] = '{
        5'd7,  5'd31, 5'd26, 5'd0,  5'd18, 5'd9,  5'd19, 5'd8,
        5'd27, 5'd6,  5'd15, 5'd21, 5'd1,  5'd28, 5'd10, 5'd20,
        5'd3,  5'd5,  5'd29, 5'd17, 5'd14, 5'd22, 5'd2,  5'd11,
        5'd23, 5'd13, 5'd24, 5'd4,  5'd16, 5'd12, 5'd25, 5'd30
    };

    // add where only masked bits pass a carry on; top carry toggles bit 0
    function automatic logic [15:0] madd16(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] m);
        logic [15:0] res;
        logic        carry;
        logic [1:0]  s;
        res   = '0;
        carry = 1'b0;
        for (int i = 0; i < 16; i++) begin
            s      = {1'b0, a[i]} + {1'b0, b[i]} + {1'b0, carry};
            res[i] = s[0];
            carry  = m[i] & s[1];
        end
        res[0] = res[0] ^ carry;
        return res;
    endfunction

    function automatic byte_t madd8(input byte_t a, input byte_t b, input byte_t m);
        byte_t      res;
        logic       carry;
        logic [1:0] s;
        res   = '0;
        carry = 1'b0;
        for (int i = 0; i < BYTE_W; i++) begin
            s      = {1'b0, a[i]} + {1'b0, b[i]} + {1'b0, carry};
            res[i] = s[0];
            carry  = m[i] & s[1];
        end
        res[0] = res[0] ^ carry;
        return res;
    endfunction

endpackage

FILE: sv/spr_if.sv
// Valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps

interface spr_feed_if;
    logic           valid;
    logic           ready;
    spr_pkg::byte_t p0_even;
    spr_pkg::byte_t p0_odd;
    spr_pkg::byte_t p1_even;
    spr_pkg::byte_t p1_odd;
    spr_pkg::byte_t p2_even;
    spr_pkg::byte_t p2_odd;

    modport source (output valid, p0_even, p0_odd, p1_even, p1_odd, p2_even, p2_odd,
                    input ready);
    modport sink   (input valid, p0_even, p0_odd, p1_even, p1_odd, p2_even, p2_odd,
                    output ready);
endinterface

interface spr_result_if;
    logic           valid;
    logic           ready;
    spr_pkg::byte_t q0_even;
    spr_pkg::byte_t q0_odd;
    spr_pkg::byte_t q1_even;
    spr_pkg::byte_t q1_odd;
    spr_pkg::byte_t q2_even;
    spr_pkg::byte_t q2_odd;
    logic           last_of_pair;

    modport source (output valid, q0_even, q0_odd, q1_even, q1_odd, q2_even, q2_odd,
                    last_of_pair, input ready);
    modport sink   (input valid, q0_even, q0_odd, q1_even, q1_odd, q2_even, q2_odd,
                    last_of_pair, output ready);
endinterface

FILE: sv/spr_store.sv
// Half-group word store: one write port, one registered read port
`timescale 1ns / 1ps

module spr_store (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [spr_pkg::ADDR_W-1:0] wr_addr,
    input  spr_pkg::item_t             wr_data,
    input  logic                       rd_en,
    input  logic [spr_pkg::ADDR_W-1:0] rd_addr,
    output spr_pkg::item_t             rd_data
);

    spr_pkg::item_t mem [spr_pkg::HALF_WORDS];
    spr_pkg::item_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/spr_decode.sv
// Plane decrypt: bit permutation, partial-carry add and key XOR; passes the item through when disabled
`timescale 1ns / 1ps

module spr_decode (
    input  logic                enable,
    input  spr_pkg::item_t      item,
    output spr_pkg::plane_out_t plane
);

    logic [31:0] w;
    logic [31:0] p;
    logic [15:0] d0;

    assign w = {item.p1_odd, item.p1_even, item.p2_odd, item.p2_even};

    always_comb
    begin
        p = '0;
        for (int i = 0; i < 32; i++) begin
            p[31-i] = w[spr_pkg::PERM_SRC[i]];
        end
    end

    assign d0 = spr_pkg::madd16({item.p0_odd, item.p0_even}, spr_pkg::P0_ADD,
                                spr_pkg::P0_CMASK) ^ spr_pkg::P0_KEY;

    always_comb
    begin
        if (enable)
        begin
            plane.q0_even = d0[15:8];
            plane.q0_odd  = d0[7:0];
            plane.q1_even = spr_pkg::madd8(p[7:0], spr_pkg::B0_ADD, spr_pkg::B0_CMASK)
                            ^ spr_pkg::B0_KEY;
            plane.q1_odd  = spr_pkg::madd8(p[15:8], spr_pkg::B1_ADD, spr_pkg::B1_CMASK)
                            ^ spr_pkg::B1_KEY;
            plane.q2_even = spr_pkg::madd8(p[23:16], spr_pkg::B2_ADD, spr_pkg::B2_CMASK)
                            ^ spr_pkg::B2_KEY;
            plane.q2_odd  = spr_pkg::madd8(p[31:24], spr_pkg::B3_ADD, spr_pkg::B3_CMASK)
                            ^ spr_pkg::B3_KEY;
        end
        else
        begin
            plane.q0_even = item.p0_even;
            plane.q0_odd  = item.p0_odd;
            plane.q1_even = item.p1_even;
            plane.q1_odd  = item.p1_odd;
            plane.q2_even = item.p2_even;
            plane.q2_odd  = item.p2_odd;
        end
    end

endmodule

FILE: sv/sprite_plane_reorder_decrypt_core.sv
// Sprite plane reorder/decrypt core: top level
// Order: for a second-half word taken, its stored partner is emitted first and the word itself after it.
// First-half words are written to the store and give no result.
// Flow: one result per cycle through the single output register while result.ready allows;
// a second-half word is held off until the previous pair's second result is loaded.
// Reset: position and handshake state clear, decrypt enable set to 1; store contents undefined.
`timescale 1ns / 1ps
`include "sprite_plane_reorder_decrypt_core_macros.svh"

module sprite_plane_reorder_decrypt_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    spr_feed_if.sink            feed,
    spr_result_if.source        result
);

    logic [spr_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      decrypt_enable_reg, decrypt_enable_next;
    logic                      s1_valid_reg, s1_valid_next;
    logic                      s1_sel_reg, s1_sel_next;
    spr_pkg::item_t            s1_cur_reg;
    logic                      out_valid_reg, out_valid_next;
    spr_pkg::plane_out_t       out_data_reg;
    logic                      out_last_reg;

    spr_pkg::item_t            feed_item;
    spr_pkg::item_t            stored_item;
    spr_pkg::item_t            sel_item;
    spr_pkg::plane_out_t       dec_plane;
    logic                      second_half;
    logic                      feed_take;
    logic                      out_load;
    logic                      s1_done;

    assign feed_item = '{p0_even: feed.p0_even, p0_odd: feed.p0_odd,
                         p1_even: feed.p1_even, p1_odd: feed.p1_odd,
                         p2_even: feed.p2_even, p2_odd: feed.p2_odd};

    assign second_half = pos_reg[spr_pkg::POS_W-1];
    assign out_load    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign s1_done     = s1_valid_reg && s1_sel_reg && out_load;
    assign feed.ready  = !second_half || !s1_valid_reg || s1_done;
    assign feed_take   = feed.valid && feed.ready;

    spr_store u_store (
        .clk     (clk),
        .wr_en   (feed_take && !second_half),
        .wr_addr (pos_reg[spr_pkg::ADDR_W-1:0]),
        .wr_data (feed_item),
        .rd_en   (feed_take && second_half),
        .rd_addr (pos_reg[spr_pkg::ADDR_W-1:0]),
        .rd_data (stored_item)
    );

    // stored partner first, then the current word
    assign sel_item = s1_sel_reg ? s1_cur_reg : stored_item;

    spr_decode u_decode (
        .enable (decrypt_enable_reg),
        .item   (sel_item),
        .plane  (dec_plane)
    );

    always_comb
    begin
        pos_next            = feed_take ? pos_reg + 1'b1 : pos_reg;
        decrypt_enable_next = cfg_wr_en ? cfg_wr_data : decrypt_enable_reg;

        s1_valid_next = s1_valid_reg;
        s1_sel_next   = s1_sel_reg;
        if (feed_take && second_half)
        begin
            s1_valid_next = 1'b1;
            s1_sel_next   = 1'b0;
        end
        else if (out_load)
        begin
            if (s1_sel_reg)
            begin
                s1_valid_next = 1'b0;
            end
            else
            begin
                s1_sel_next = 1'b1;
            end
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg            <= '0;
            decrypt_enable_reg <= 1'b1;
            s1_valid_reg       <= 1'b0;
            s1_sel_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            pos_reg            <= pos_next;
            decrypt_enable_reg <= decrypt_enable_next;
            s1_valid_reg       <= s1_valid_next;
            s1_sel_reg         <= s1_sel_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed_take && second_half)
        begin
            s1_cur_reg <= feed_item;
        end
        if (out_load)
        begin
            out_data_reg <= dec_plane;
            out_last_reg <= s1_sel_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.q0_even      = out_data_reg.q0_even;
    assign result.q0_odd       = out_data_reg.q0_odd;
    assign result.q1_even      = out_data_reg.q1_even;
    assign result.q1_odd       = out_data_reg.q1_odd;
    assign result.q2_even      = out_data_reg.q2_even;
    assign result.q2_odd       = out_data_reg.q2_odd;
    assign result.last_of_pair = out_last_reg;

    `SPR_ASSERT_IMP(a_no_pair_overrun, feed_take && second_half, !s1_valid_reg || s1_done, "pair stage overwritten while busy")
    `SPR_ASSERT_NEXT(a_pair_starts, feed_take && second_half, s1_valid_reg && !s1_sel_reg, "second-half word did not start a pair")
    `SPR_ASSERT_NEXT(a_second_is_last, s1_done, result.valid && result.last_of_pair, "second result of pair not marked last")

endmodule

FILE: test/reorder_decode_watch.sv
// Watches the feed, result and register ports, predicts each result word and compares it
`timescale 1ns / 1ps

module reorder_decode_watch (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_wr_en,
    input  logic   cfg_wr_data,
    spr_feed_if    feed,
    spr_result_if  result,
    output int     errors,
    output int     awaiting
);
    import spr_pkg::*;

    typedef struct packed {
        plane_out_t planes;
        logic       last_of_pair;
    } due_word_t;

    localparam logic [15:0] LOW_ADD = 16'h018a, LOW_CARRY = 16'h018a, LOW_XOR = 16'hccd8;
    localparam logic [7:0]  A0 = 8'h05, C0 = 8'h1d, X0 = 8'h6c;
    localparam logic [7:0]  A1 = 8'h42, C1 = 8'h46, X1 = 8'ha2;
    localparam logic [7:0]  A2 = 8'h21, C2 = 8'h27, X2 = 8'h52;
    localparam logic [7:0]  A3 = 8'h08, C3 = 8'h08, X3 = 8'h3a;

    // bit 31-i of the shuffled word is taken from bit BIT_FROM[i]
    localparam logic [4:0] BIT_FROM [0:31] = '{
        5'd7,  5'd31, 5'd26, 5'd0,  5'd18, 5'd9,  5'd19, 5'd8,
        5'd27, 5'd6,  5'd15, 5'd21, 5'd1,  5'd28, 5'd10, 5'd20,
        5'd3,  5'd5,  5'd29, 5'd17, 5'd14, 5'd22, 5'd2,  5'd11,
        5'd23, 5'd13, 5'd24, 5'd4,  5'd16, 5'd12, 5'd25, 5'd30
    };

    item_t            first_half [HALF_WORDS];
    logic [POS_W-1:0] slot;
    logic             decode_on;
    due_word_t        words_due [$];

    // carry passes only where m is set; carry out of the top toggles bit 0
    function automatic logic [15:0] gated_sum(input logic [15:0] a, input logic [15:0] b,
                                              input logic [15:0] m, input int nbits);
        logic [15:0] acc;
        logic        c;
        acc = '0;
        c   = 1'b0;
        for (int i = 0; i < nbits; i++)
        begin
            acc[i] = a[i] ^ b[i] ^ c;
            c      = m[i] & ((a[i] & b[i]) | (c & (a[i] ^ b[i])));
        end
        acc[0] = acc[0] ^ c;
        return acc;
    endfunction

    function automatic logic [7:0] byte_key(input logic [7:0] v, input logic [7:0] add,
                                            input logic [7:0] m, input logic [7:0] x);
        logic [15:0] s;
        s = gated_sum({8'h00, v}, {8'h00, add}, {8'h00, m}, 8);
        return s[7:0] ^ x;
    endfunction

    function automatic plane_out_t decode_word(input item_t w, input logic on);
        plane_out_t  o;
        logic [31:0] joined;
        logic [31:0] shuffled;
        logic [15:0] low;
        o.q0_even = w.p0_even;
        o.q0_odd  = w.p0_odd;
        o.q1_even = w.p1_even;
        o.q1_odd  = w.p1_odd;
        o.q2_even = w.p2_even;
        o.q2_odd  = w.p2_odd;
        if (on)
        begin
            joined = {w.p1_odd, w.p1_even, w.p2_odd, w.p2_even};
            for (int i = 0; i < 32; i++)
                shuffled[31-i] = joined[BIT_FROM[i]];
            low = gated_sum({w.p0_odd, w.p0_even}, LOW_ADD, LOW_CARRY, 16) ^ LOW_XOR;
            o.q0_even = low[15:8];
            o.q0_odd  = low[7:0];
            o.q1_even = byte_key(shuffled[7:0],   A0, C0, X0);
            o.q1_odd  = byte_key(shuffled[15:8],  A1, C1, X1);
            o.q2_even = byte_key(shuffled[23:16], A2, C2, X2);
            o.q2_odd  = byte_key(shuffled[31:24], A3, C3, X3);
        end
        return o;
    endfunction

    task automatic field_check(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%t mismatch %s: expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t     w;
        due_word_t d;
        if (!rst_n)
        begin
            slot      = '0;
            decode_on = 1'b1;
            errors    = 0;
            words_due.delete();
            awaiting  = 0;
        end
        else
        begin
            if (cfg_wr_en)
                decode_on = cfg_wr_data;

            if (result.valid && result.ready)
            begin
                if (words_due.size() == 0)
                begin
                    errors++;
                    $display("%t unexpected result word %h%h%h%h%h%h last %b", $time,
                             result.q0_even, result.q0_odd, result.q1_even, result.q1_odd,
                             result.q2_even, result.q2_odd, result.last_of_pair);
                end
                else
                begin
                    d = words_due.pop_front();
                    field_check("q0_even", d.planes.q0_even, result.q0_even);
                    field_check("q0_odd",  d.planes.q0_odd,  result.q0_odd);
                    field_check("q1_even", d.planes.q1_even, result.q1_even);
                    field_check("q1_odd",  d.planes.q1_odd,  result.q1_odd);
                    field_check("q2_even", d.planes.q2_even, result.q2_even);
                    field_check("q2_odd",  d.planes.q2_odd,  result.q2_odd);
                    field_check("last_of_pair", {7'd0, d.last_of_pair},
                                {7'd0, result.last_of_pair});
                end
            end

            if (feed.valid && feed.ready)
            begin
                w = {feed.p0_even, feed.p0_odd, feed.p1_even, feed.p1_odd,
                     feed.p2_even, feed.p2_odd};
                if (slot < HALF_WORDS)
                    first_half[slot[ADDR_W-1:0]] = w;
                else
                begin
                    words_due.push_back({decode_word(first_half[slot[ADDR_W-1:0]], decode_on),
                                         1'b0});
                    words_due.push_back({decode_word(w, decode_on), 1'b1});
                end
                slot = slot + 1'b1;
            end

            awaiting = words_due.size();
        end
    end

endmodule

FILE: test/tb.sv
// Top level of the sprite plane reorder/decrypt test: stimulus, handshake timing and verdict
`timescale 1ns / 1ps

module tb;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    int   errors;
    int   awaiting;
    logic hold_off;
    logic tx_steady;
    logic rx_steady;

    spr_feed_if   feed ();
    spr_result_if result ();

    sprite_plane_reorder_decrypt_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .feed        (feed),
        .result      (result)
    );

    reorder_decode_watch watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .feed        (feed),
        .result      (result),
        .errors      (errors),
        .awaiting    (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

    function automatic spr_pkg::byte_t pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return spr_pkg::byte_t'($urandom);
        endcase
    endfunction

    function automatic spr_pkg::item_t random_word();
        return {pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte()};
    endfunction

    // field order: p0_even p0_odd p1_even p1_odd p2_even p2_odd
    function automatic spr_pkg::item_t directed_word(input int k);
        case (k)
            0:       return '0;
            1:       return '1;
            2:       return {6{8'h55}};
            3:       return {6{8'haa}};
            4:       return 48'h76fe_0000_0000;
            5:       return 48'hffff_0000_0000;
            6:       return 48'h0000_ffff_ffff;
            7:       return 48'h0000_0180_0201;
            8:       return 48'h0100_4020_1008;
            9:       return 48'h0080_0804_0280;
            16:      return '1;
            17:      return '0;
            18:      return 48'h5555_aaaa_5555;
            19:      return 48'haaaa_5555_aaaa;
            20:      return 48'h0000_fbde_bbf7;
            21:      return 48'hfe75_0000_0000;
            default: return random_word();
        endcase
    endfunction

    task automatic send_word(input spr_pkg::item_t w);
        int   gap;
        logic took;
        gap = tx_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            feed.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        feed.valid   <= 1'b1;
        feed.p0_even <= w.p0_even;
        feed.p0_odd  <= w.p0_odd;
        feed.p1_even <= w.p1_even;
        feed.p1_odd  <= w.p1_odd;
        feed.p2_even <= w.p2_even;
        feed.p2_odd  <= w.p2_odd;
        do
        begin
            @(negedge clk);
            took = feed.ready;
            @(posedge clk);
        end
        while (!took);
        if ($urandom_range(0, 40) == 0)
            tx_steady = !tx_steady;
    endtask

    // drop valid, let every due word arrive and the store write finish
    task automatic settle();
        feed.valid <= 1'b0;
        @(posedge clk);
        wait (awaiting == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_enable(input logic v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_half(input int first);
        for (int k = first; k < first + spr_pkg::HALF_WORDS; k++)
            send_word(random_word());
    endtask

    // result side
    initial
    begin
        int   stall;
        logic took;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off)
            begin
                result.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            stall = rx_steady ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = result.valid;
                @(posedge clk);
            end
            while (!took);
            if ($urandom_range(0, 40) == 0)
                rx_steady = !rx_steady;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        hold_off       = 1'b0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        feed.valid     = 1'b0;
        feed.p0_even   = '0;
        feed.p0_odd    = '0;
        feed.p1_even   = '0;
        feed.p1_odd    = '0;
        feed.p2_even   = '0;
        feed.p2_odd    = '0;
        result.ready   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_enable(1'b1);
        for (int k = 0; k < spr_pkg::GROUP_WORDS; k++)
            send_word(directed_word(k));
        settle();

        // setting changed between store and emission
        send_half(0);
        settle();
        write_enable(1'b0);
        send_half(spr_pkg::HALF_WORDS);
        settle();
        send_half(0);
        settle();
        write_enable(1'b1);
        send_half(spr_pkg::HALF_WORDS);
        settle();

        for (int g = 0; g < 10; g++)
        begin
            if ($urandom_range(0, 1))
                write_enable(1'($urandom_range(0, 1)));
            for (int k = 0; k < spr_pkg::GROUP_WORDS; k++)
            begin
                if (g == 3 && k == spr_pkg::HALF_WORDS)
                    hold_off = 1'b1;
                if (g == 6 && k == 20)
                    settle();
                if (k == spr_pkg::HALF_WORDS && $urandom_range(0, 3) == 0)
                begin
                    settle();
                    write_enable(1'($urandom_range(0, 1)));
                end
                send_word(random_word());
            end
            settle();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/spr_pkg.sv
sv/spr_if.sv
sv/spr_store.sv
sv/spr_decode.sv
sv/sprite_plane_reorder_decrypt_core.sv
test/reorder_decode_watch.sv
test/tb.sv
